FILE: rtl/scs1_pkg.sv
// ----------------------------------------------------------------------------
// Scancode set 1 decoder package
// Shared types, scancode constants and character tables for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package scs1_pkg;

    localparam logic [7:0] SC_PREFIX_EXT  = 8'hE0;
    localparam logic [6:0] SC_SHIFT_LEFT  = 7'h2A;
    localparam logic [6:0] SC_SHIFT_RIGHT = 7'h36;
    localparam logic [6:0] SC_CAPS        = 7'h3A;

    typedef struct packed {
        logic [6:0] key_code;
        logic       extended;
        logic [6:0] ascii_char;
        logic       ascii_valid;
    } t_key_event;

    // Decoder result for one scancode byte
    typedef struct packed {
        logic       emit;
        t_key_event evt;
    } t_decode_out;

    function automatic logic [6:0] base_char(input logic [6:0] code);
        logic [6:0] c;
        c = 7'h00;
        unique case (code)
            7'd1:    c = 7'h1B;
            7'd2:    c = 7'h31;
            7'd3:    c = 7'h32;
            7'd4:    c = 7'h33;
            7'd5:    c = 7'h34;
            7'd6:    c = 7'h35;
            7'd7:    c = 7'h36;
            7'd8:    c = 7'h37;
            7'd9:    c = 7'h38;
            7'd10:   c = 7'h39;
            7'd11:   c = 7'h30;
            7'd12:   c = 7'h2D;
            7'd13:   c = 7'h3D;
            7'd14:   c = 7'h08;
            7'd15:   c = 7'h09;
            7'd16:   c = 7'h71;
            7'd17:   c = 7'h77;
            7'd18:   c = 7'h65;
            7'd19:   c = 7'h72;
            7'd20:   c = 7'h74;
            7'd21:   c = 7'h79;
            7'd22:   c = 7'h75;
            7'd23:   c = 7'h69;
            7'd24:   c = 7'h6F;
            7'd25:   c = 7'h70;
            7'd26:   c = 7'h5B;
            7'd27:   c = 7'h5D;
            7'd28:   c = 7'h0A;
            7'd30:   c = 7'h61;
            7'd31:   c = 7'h73;
            7'd32:   c = 7'h64;
            7'd33:   c = 7'h66;
            7'd34:   c = 7'h67;
            7'd35:   c = 7'h68;
            7'd36:   c = 7'h6A;
            7'd37:   c = 7'h6B;
            7'd38:   c = 7'h6C;
            7'd39:   c = 7'h3B;
            7'd40:   c = 7'h27;
            7'd41:   c = 7'h60;
            7'd43:   c = 7'h5C;
            7'd44:   c = 7'h7A;
            7'd45:   c = 7'h78;
            7'd46:   c = 7'h63;
            7'd47:   c = 7'h76;
            7'd48:   c = 7'h62;
            7'd49:   c = 7'h6E;
            7'd50:   c = 7'h6D;
            7'd51:   c = 7'h2C;
            7'd52:   c = 7'h2E;
            7'd53:   c = 7'h2F;
            7'd55:   c = 7'h2A;
            7'd57:   c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] shift_char(input logic [6:0] code);
        logic [6:0] c;
        c = 7'h00;
        unique case (code)
            7'd1:    c = 7'h1B;
            7'd2:    c = 7'h21;
            7'd3:    c = 7'h40;
            7'd4:    c = 7'h23;
            7'd5:    c = 7'h24;
            7'd6:    c = 7'h25;
            7'd7:    c = 7'h5E;
            7'd8:    c = 7'h26;
            7'd9:    c = 7'h2A;
            7'd10:   c = 7'h28;
            7'd11:   c = 7'h29;
            7'd12:   c = 7'h5F;
            7'd13:   c = 7'h2B;
            7'd14:   c = 7'h08;
            7'd15:   c = 7'h09;
            7'd16:   c = 7'h51;
            7'd17:   c = 7'h57;
            7'd18:   c = 7'h45;
            7'd19:   c = 7'h52;
            7'd20:   c = 7'h54;
            7'd21:   c = 7'h59;
            7'd22:   c = 7'h55;
            7'd23:   c = 7'h49;
            7'd24:   c = 7'h4F;
            7'd25:   c = 7'h50;
            7'd26:   c = 7'h7B;
            7'd27:   c = 7'h7D;
            7'd28:   c = 7'h0A;
            7'd30:   c = 7'h41;
            7'd31:   c = 7'h53;
            7'd32:   c = 7'h44;
            7'd33:   c = 7'h46;
            7'd34:   c = 7'h47;
            7'd35:   c = 7'h48;
            7'd36:   c = 7'h4A;
            7'd37:   c = 7'h4B;
            7'd38:   c = 7'h4C;
            7'd39:   c = 7'h3A;
            7'd40:   c = 7'h22;
            7'd41:   c = 7'h7E;
            7'd43:   c = 7'h7C;
            7'd44:   c = 7'h5A;
            7'd45:   c = 7'h58;
            7'd46:   c = 7'h43;
            7'd47:   c = 7'h56;
            7'd48:   c = 7'h42;
            7'd49:   c = 7'h4E;
            7'd50:   c = 7'h4D;
            7'd51:   c = 7'h3C;
            7'd52:   c = 7'h3E;
            7'd53:   c = 7'h3F;
            7'd55:   c = 7'h2A;
            7'd57:   c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Swap letter case; bit 5 separates upper and lower case in ASCII
    function automatic logic [6:0] flip_case(input logic [6:0] c);
        logic is_upper;
        logic is_lower;
        is_upper = (c >= 7'h41) && (c <= 7'h5A);
        is_lower = (c >= 7'h61) && (c <= 7'h7A);
        return (is_upper || is_lower) ? (c ^ 7'h20) : c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/scs1_in_stage.sv
// ----------------------------------------------------------------------------
// Scancode input register
// Captures one scancode byte per transaction and holds it until decoded.
// ----------------------------------------------------------------------------
`default_nettype none

module scs1_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,
    input  wire logic       i_advance,
    output logic            o_valid,
    output logic [7:0]      o_data
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       n_valid;
    logic       w_load;

    assign o_s_tready = !r_valid || i_advance;
    assign w_load     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_s_tdata;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

FILE: rtl/scs1_decode.sv
// ----------------------------------------------------------------------------
// Scancode decoder
// Tracks shift, caps lock and extended prefix; translates make codes.
// ----------------------------------------------------------------------------
`default_nettype none

module scs1_decode (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_fire,
    input  wire logic [7:0]   i_scancode,
    output scs1_pkg::t_decode_out o_dec
);

    logic       r_shift_held;
    logic       r_caps_lock;
    logic       r_ext_pending;
    logic       n_shift_held;
    logic       n_caps_lock;
    logic       n_ext_pending;

    logic       w_prefix;
    logic       w_release;
    logic [6:0] w_code;
    logic       w_is_shift;
    logic       w_is_caps;
    logic [6:0] w_base;
    logic [6:0] w_sel;
    logic       w_valid;

    assign w_prefix   = (i_scancode == scs1_pkg::SC_PREFIX_EXT);
    assign w_release  = i_scancode[7];
    assign w_code     = i_scancode[6:0];
    assign w_is_shift = (w_code == scs1_pkg::SC_SHIFT_LEFT) ||
                        (w_code == scs1_pkg::SC_SHIFT_RIGHT);
    assign w_is_caps  = (w_code == scs1_pkg::SC_CAPS);

    always_comb begin
        n_shift_held  = r_shift_held;
        n_caps_lock   = r_caps_lock;
        n_ext_pending = r_ext_pending;
        if (i_fire) begin
            if (w_prefix) begin
                n_ext_pending = 1'b1;
            end else begin
                n_ext_pending = 1'b0;
                if (w_is_shift) begin
                    n_shift_held = !w_release;
                end
                if (w_is_caps && !w_release) begin
                    n_caps_lock = !r_caps_lock;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_held  <= 1'b0;
            r_caps_lock   <= 1'b0;
            r_ext_pending <= 1'b0;
        end else begin
            r_shift_held  <= n_shift_held;
            r_caps_lock   <= n_caps_lock;
            r_ext_pending <= n_ext_pending;
        end
    end

    // Character lookup, gated off for extended and unmapped keys
    assign w_base  = scs1_pkg::base_char(w_code);
    assign w_valid = !r_ext_pending && (w_base != 7'h00);
    assign w_sel   = r_shift_held ? scs1_pkg::shift_char(w_code) : w_base;

    always_comb begin
        o_dec.emit            = !w_prefix && !w_is_shift && !w_is_caps && !w_release;
        o_dec.evt.key_code    = w_code;
        o_dec.evt.extended    = r_ext_pending;
        o_dec.evt.ascii_valid = w_valid;
        if (!w_valid) begin
            o_dec.evt.ascii_char = 7'h00;
        end else if (r_caps_lock) begin
            o_dec.evt.ascii_char = scs1_pkg::flip_case(w_sel);
        end else begin
            o_dec.evt.ascii_char = w_sel;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/scs1_out_stage.sv
// ----------------------------------------------------------------------------
// Key event output register
// Holds one key event until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module scs1_out_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire scs1_pkg::t_key_event i_evt,
    input  wire logic                 i_m_tready,
    output logic                      o_m_tvalid,
    output scs1_pkg::t_key_event      o_evt,
    output logic                      o_free
);

    logic                 r_valid;
    logic                 n_valid;
    scs1_pkg::t_key_event r_evt;

    assign o_free = !r_valid || i_m_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_evt <= i_evt;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_evt      = r_evt;

endmodule

`default_nettype wire

FILE: rtl/scancode_set1_to_ascii.sv
// ----------------------------------------------------------------------------
// Scancode set 1 to ASCII decoder
// Turns raw keyboard bytes into key events with translated characters.
// ----------------------------------------------------------------------------
// Path: a byte is held in the input register, then its event in the event register.
// Throughput: one byte per cycle; the input register and the event register
//   advance together, so a byte is taken whenever the event register is free.
// Reset: synchronous, active low; clears shift, caps lock, the pending prefix
//   and both valid flags.
`default_nettype none

module scancode_set1_to_ascii (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] scancode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [6:0] key_code, [13:7] ascii_char, [15:14] zero
    output logic [1:0]       o_m_tuser    // [0] extended, [1] ascii_valid
);

    logic                    w_in_valid;
    logic [7:0]              w_in_data;
    logic                    w_advance;
    logic                    w_out_free;
    scs1_pkg::t_decode_out   w_dec;
    scs1_pkg::t_key_event    w_evt;

    // Move the held byte forward once the event register can take a result
    assign w_advance = w_in_valid && w_out_free;

    scs1_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_advance  (w_advance),
        .o_valid    (w_in_valid),
        .o_data     (w_in_data)
    );

    scs1_decode u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_advance),
        .i_scancode (w_in_data),
        .o_dec      (w_dec)
    );

    scs1_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance && w_dec.emit),
        .i_evt      (w_dec.evt),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_evt      (w_evt),
        .o_free     (w_out_free)
    );

    assign o_m_tdata = {2'b00, w_evt.ascii_char, w_evt.key_code};
    assign o_m_tuser = {w_evt.ascii_valid, w_evt.extended};

    // An extended key never carries a character
    a_valid_not_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> !o_m_tuser[0])
        else $error("ascii_valid set on extended key");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[1]) |-> (o_m_tdata[13:7] == 7'h00))
        else $error("character present without ascii_valid");

    // Modifier keys update state only
    a_no_modifier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[6:0] != scs1_pkg::SC_SHIFT_LEFT) &&
                        (o_m_tdata[6:0] != scs1_pkg::SC_SHIFT_RIGHT) &&
                        (o_m_tdata[6:0] != scs1_pkg::SC_CAPS)))
        else $error("modifier key emitted as event");

    // A held byte with a stalled output must block new transactions
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while pipeline is full");

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scancode set 1 decoder testbench
// Streams keyboard byte sequences into the decoder under random idling on
// both sides, predicts every key event in step with the accepted bytes and
// checks each output transaction field by field.
// ----------------------------------------------------------------------------

module testbench;

    localparam int unsigned IDLE_LIMIT = 500;

    typedef struct {
        logic [7:0]  code;
        int unsigned gap;
        bit          drain;
    } t_scan_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic [7:0]  in_data = '0;
    int unsigned in_wait = 0;
    logic        out_ready = 1'b0;
    int unsigned out_wait = 0;

    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    t_scan_item            scan_q[$];
    scs1_pkg::t_key_event  key_q[$];

    int unsigned n_sent = 0;
    int unsigned n_pred = 0;
    int unsigned n_seen = 0;
    int unsigned idle_cnt = 0;
    int unsigned err_cnt = 0;

    logic [6:0]  base_tbl [128];
    logic [6:0]  shift_tbl [128];
    logic        shift_on = 1'b0;
    logic        caps_on = 1'b0;
    logic        ext_armed = 1'b0;

    scancode_set1_to_ascii DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (in_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (in_data),     // [7:0] scancode
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (out_ready),
        .o_m_tdata  (o_m_tdata),   // [6:0] key_code, [13:7] ascii_char, [15:14] zero
        .o_m_tuser  (o_m_tuser)    // [0] extended, [1] ascii_valid
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_idle();
        return $urandom_range(0, 6);
    endfunction

    // Advance the keyboard state by one byte; return 1 when a key event results
    function automatic bit decode_byte(input logic [7:0] sc,
                                       output scs1_pkg::t_key_event ev);
        logic [6:0] code;
        logic       brk;
        logic       ext;
        logic [6:0] ch;
        ev = '0;
        if (sc == scs1_pkg::SC_PREFIX_EXT) begin
            ext_armed = 1'b1;
            return 1'b0;
        end
        brk = sc[7];
        code = sc[6:0];
        ext = ext_armed;
        ext_armed = 1'b0;
        if (code == scs1_pkg::SC_SHIFT_LEFT || code == scs1_pkg::SC_SHIFT_RIGHT) begin
            shift_on = !brk;
            return 1'b0;
        end
        if (code == scs1_pkg::SC_CAPS) begin
            if (!brk)
                caps_on = !caps_on;
            return 1'b0;
        end
        if (brk)
            return 1'b0;
        ev.key_code = code;
        ev.extended = ext;
        if (!ext && base_tbl[code] != 7'd0) begin
            ch = shift_on ? shift_tbl[code] : base_tbl[code];
            // caps lock swaps case of letters only
            if (caps_on && ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")))
                ch = ch ^ 7'h20;
            ev.ascii_char = ch;
            ev.ascii_valid = 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic push_scan(input logic [7:0] code, input bit drain = 1'b0);
        t_scan_item it;
        it.code = code;
        it.drain = drain;
        // leave runs of back-to-back transactions
        it.gap = ((scan_q.size() / 150) % 4 == 2) ? 0 : draw_idle();
        scan_q.push_back(it);
    endtask

    task automatic cmp_field(input string name, input logic [6:0] want_v,
                             input logic [6:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %h, actual %h", name, want_v, got_v);
            err_cnt++;
        end
    endtask

    // Input side: present queued bytes, predict on each accepted transaction
    always @(posedge i_clk) begin : drive_scan
        scs1_pkg::t_key_event ev;
        bit                   done;
        int                   open_cnt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_wait <= 0;
        end else begin
            done = in_valid && o_s_tready;
            open_cnt = int'(n_pred) - int'(n_seen);
            if (done) begin
                n_sent <= n_sent + 1;
                if (decode_byte(in_data, ev)) begin
                    key_q.push_back(ev);
                    n_pred <= n_pred + 1;
                    open_cnt++;
                end
            end
            if (!in_valid || done) begin
                if (in_wait != 0) begin
                    in_valid <= 1'b0;
                    in_wait <= in_wait - 1;
                end else if (scan_q.size() == 0 || (scan_q[0].drain && open_cnt != 0)) begin
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_data <= scan_q[0].code;
                    in_wait <= scan_q[0].gap;
                    void'(scan_q.pop_front());
                end
            end
        end
    end

    // Output side: random back-pressure, compare against the oldest prediction
    always @(posedge i_clk) begin : watch_keys
        scs1_pkg::t_key_event  want;
        int unsigned           stall;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_wait <= 0;
        end else if (o_m_tvalid && out_ready) begin
            if (key_q.size() == 0) begin
                $error("unexpected key event: tdata %h, tuser %h", o_m_tdata, o_m_tuser);
                err_cnt++;
            end else begin
                want = key_q.pop_front();
                n_seen <= n_seen + 1;
                cmp_field("key_code", want.key_code, o_m_tdata[6:0]);
                cmp_field("ascii_char", want.ascii_char, o_m_tdata[13:7]);
                cmp_field("extended", 7'(want.extended), 7'(o_m_tuser[0]));
                cmp_field("ascii_valid", 7'(want.ascii_valid), 7'(o_m_tuser[1]));
            end
            stall = (n_seen % 100 < 25) ? 0 : draw_idle();
            out_ready <= (stall == 0);
            out_wait <= stall;
        end else if (out_wait != 0) begin
            out_wait <= out_wait - 1;
            out_ready <= (out_wait == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((in_valid && o_s_tready) || (o_m_tvalid && out_ready))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        string       base_a = "\0331234567890-=\010\011qwertyuiop[]\012";
        string       base_b = "asdfghjkl;'\140";
        string       base_c = "\\zxcvbnm,./";
        string       shift_a = "\033!@#$%^&*()_+\010\011QWERTYUIOP{}\012";
        string       shift_b = "ASDFGHJKL:\"~";
        string       shift_c = "|ZXCVBNM<>?";
        int unsigned n_total;
        int unsigned pick;
        logic [7:0]  code;
        bit          ext;

        for (int k = 0; k < 128; k++) begin
            base_tbl[k] = '0;
            shift_tbl[k] = '0;
        end
        for (int k = 0; k < 28; k++) begin
            base_tbl[1 + k] = 7'(base_a[k]);
            shift_tbl[1 + k] = 7'(shift_a[k]);
        end
        for (int k = 0; k < 12; k++) begin
            base_tbl[30 + k] = 7'(base_b[k]);
            shift_tbl[30 + k] = 7'(shift_b[k]);
        end
        for (int k = 0; k < 11; k++) begin
            base_tbl[43 + k] = 7'(base_c[k]);
            shift_tbl[43 + k] = 7'(shift_c[k]);
        end
        base_tbl[55] = 7'("*");
        shift_tbl[55] = 7'("*");
        base_tbl[57] = 7'(" ");
        shift_tbl[57] = 7'(" ");

        // plain keys, lowest and highest codes
        push_scan(8'h1E);
        push_scan(8'h02);
        push_scan(8'h00);
        push_scan(8'h7F);
        push_scan(8'h39);
        // shifted keys, then release shift
        push_scan({1'b0, scs1_pkg::SC_SHIFT_LEFT});
        push_scan(8'h1E);
        push_scan(8'h02);
        push_scan(8'h35);
        push_scan({1'b1, scs1_pkg::SC_SHIFT_LEFT});
        // caps lock on, with and without shift; caps break must not toggle
        push_scan({1'b0, scs1_pkg::SC_CAPS});
        push_scan(8'h1E);
        push_scan({1'b0, scs1_pkg::SC_SHIFT_RIGHT});
        push_scan(8'h1E);
        push_scan({1'b1, scs1_pkg::SC_SHIFT_RIGHT});
        push_scan({1'b1, scs1_pkg::SC_CAPS});
        push_scan(8'h10);
        push_scan({1'b0, scs1_pkg::SC_CAPS});
        // extended key, repeated prefix, extended shift make and break
        push_scan(scs1_pkg::SC_PREFIX_EXT);
        push_scan(8'h1C);
        push_scan(scs1_pkg::SC_PREFIX_EXT);
        push_scan(scs1_pkg::SC_PREFIX_EXT);
        push_scan(8'h48);
        push_scan(scs1_pkg::SC_PREFIX_EXT);
        push_scan({1'b0, scs1_pkg::SC_SHIFT_LEFT});
        push_scan(8'h1E);
        push_scan(scs1_pkg::SC_PREFIX_EXT);
        push_scan({1'b1, scs1_pkg::SC_SHIFT_LEFT});
        // a break byte consumes the prefix
        push_scan(scs1_pkg::SC_PREFIX_EXT);
        push_scan(8'h9C);
        push_scan(8'h1C);
        push_scan(8'hFF);
        push_scan(8'h80, 1'b1);

        while (scan_q.size() < 900) begin
            pick = $urandom_range(0, 9);
            if (pick <= 4) begin
                // key tap: make, usually followed by its break
                code = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127))
                                                   : 8'($urandom_range(1, 57));
                ext = ($urandom_range(0, 4) == 0);
                if (ext)
                    push_scan(scs1_pkg::SC_PREFIX_EXT);
                push_scan(code, (scan_q.size() % 250) < 2);
                if ($urandom_range(0, 3) != 0) begin
                    if (ext)
                        push_scan(scs1_pkg::SC_PREFIX_EXT);
                    push_scan(code | 8'h80);
                end
            end else if (pick == 5) begin
                push_scan({1'b0, ($urandom_range(0, 1) == 1) ? scs1_pkg::SC_SHIFT_LEFT
                                                             : scs1_pkg::SC_SHIFT_RIGHT});
            end else if (pick == 6) begin
                push_scan({1'b1, ($urandom_range(0, 1) == 1) ? scs1_pkg::SC_SHIFT_LEFT
                                                             : scs1_pkg::SC_SHIFT_RIGHT});
            end else if (pick == 7) begin
                push_scan({1'b0, scs1_pkg::SC_CAPS});
                push_scan({1'b1, scs1_pkg::SC_CAPS});
            end else if (pick == 8) begin
                push_scan(8'($urandom_range(0, 255)));
            end else begin
                push_scan(scs1_pkg::SC_PREFIX_EXT);
                push_scan(8'($urandom_range(0, 255)));
            end
        end
        n_total = scan_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != n_total || n_pred != n_seen)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (err_cnt == 0 && key_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
